[rtl/gsa_pkg.sv]
package gsa_pkg;

  // Field widths of the handle and result ports
  localparam int HANDLE_IDX_W = 10;
  localparam int GEN_W        = 32;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

endpackage

[rtl/generational_slot_allocator_core.sv]
// Generational slot allocator: hands out (index, generation) handles from a pool of
// SLOT_COUNT slots. The free list and the per-slot generation counters live in two
// synchronous memories addressed by slot; free_head is the only list state kept in
// flip-flops. Each operation first accepts the transfer and issues the memory read, then
// uses the read data, loads the result register and, on a release, writes back the slot
// entry. A result that waits on out_stall holds the execute state until the result
// register frees. After reset the block runs a clearing pass over all SLOT_COUNT slots that
// builds the initial free list and zeroes all generations; in_stall stays high during it.
// Opcode 0 acquires, 1 releases a handle, 2 checks a handle; status reports ok, pool full
// on acquire, or invalid handle on release. Exactly one result follows every transfer.
module generational_slot_allocator_core #(
  parameter int SLOT_COUNT = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // operation input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [gsa_pkg::OP_W-1:0]       in_opcode,
  input  logic [gsa_pkg::HANDLE_IDX_W-1:0] in_handle_index,
  input  logic [gsa_pkg::GEN_W-1:0]      in_handle_generation,
  // result output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [gsa_pkg::HANDLE_IDX_W-1:0] out_slot_index,
  output logic [gsa_pkg::GEN_W-1:0]      out_slot_generation,
  output logic                           out_handle_valid,
  output logic [gsa_pkg::STATUS_W-1:0]   out_status
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PTR_W = $clog2(SLOT_COUNT + 1);
  localparam logic [PTR_W-1:0] EMPTY_MARK = PTR_W'(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(SLOT_COUNT - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  // State and free-list head
  logic [1:0]       state_r, state_nxt;
  logic [PTR_W-1:0] free_head_r, free_head_nxt;
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // Latched operation
  logic [gsa_pkg::OP_W-1:0]         op_r;
  logic [gsa_pkg::HANDLE_IDX_W-1:0] hidx_r;
  logic [gsa_pkg::GEN_W-1:0]        hgen_r;
  logic [IDX_W-1:0]                 addr_r;
  logic                             in_range_r;
  logic                             full_r;

  // Memories
  logic [PTR_W-1:0]          next_mem [SLOT_COUNT];
  logic [gsa_pkg::GEN_W-1:0] gen_mem  [SLOT_COUNT];
  logic [PTR_W-1:0]          next_rd_r;
  logic [gsa_pkg::GEN_W-1:0] gen_rd_r;

  logic [IDX_W-1:0]          rd_addr;
  logic                      we;
  logic [IDX_W-1:0]          wr_addr;
  logic [PTR_W-1:0]          wr_next;
  logic [gsa_pkg::GEN_W-1:0] wr_gen;

  // Output register
  logic                             out_valid_r, out_valid_nxt;
  logic [gsa_pkg::HANDLE_IDX_W-1:0] out_idx_r;
  logic [gsa_pkg::GEN_W-1:0]        out_gen_r;
  logic                             out_hv_r;
  logic [gsa_pkg::STATUS_W-1:0]     out_status_r;

  logic                             accept;
  logic                             can_load;
  logic                             gen_match;
  logic [31:0]                      in_idx_ext;
  logic [31:0]                      head_ext;
  logic [gsa_pkg::HANDLE_IDX_W-1:0] res_idx;
  logic [gsa_pkg::GEN_W-1:0]        res_gen;
  logic                             res_hv;
  logic [gsa_pkg::STATUS_W-1:0]     res_status;

  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && (state_r == S_IDLE);
  assign can_load   = !out_valid_r || !out_stall;
  assign in_idx_ext = 32'(in_handle_index);
  assign head_ext   = 32'(free_head_r);
  assign gen_match  = in_range_r && (gen_rd_r == hgen_r);

  // Pick the read address: the list head for acquire, the handle slot otherwise
  always_comb begin
    if (state_r == S_IDLE) begin
      if (in_opcode == gsa_pkg::OP_ACQUIRE) begin
        rd_addr = free_head_r[IDX_W-1:0];
      end else begin
        rd_addr = in_idx_ext[IDX_W-1:0];
      end
    end else begin
      rd_addr = addr_r;
    end
  end

  // Build the result and the write-back from the read data
  always_comb begin
    res_idx       = hidx_r;
    res_gen       = '0;
    res_hv        = 1'b0;
    res_status    = gsa_pkg::ST_OK;
    free_head_nxt = free_head_r;
    we            = 1'b0;
    wr_addr       = addr_r;
    wr_next       = free_head_r;
    wr_gen        = gen_rd_r + 1'b1;
    unique case (op_r)
      gsa_pkg::OP_ACQUIRE: begin
        if (full_r) begin
          res_status = gsa_pkg::ST_FULL;
        end else begin
          res_idx = head_ext[gsa_pkg::HANDLE_IDX_W-1:0];
          res_gen = gen_rd_r;
          if (state_r == S_EXEC && can_load) begin
            free_head_nxt = next_rd_r;
          end
        end
      end
      gsa_pkg::OP_RELEASE: begin
        if (gen_match) begin
          res_hv = 1'b1;
          if (state_r == S_EXEC && can_load) begin
            we            = 1'b1;
            free_head_nxt = PTR_W'(addr_r);
          end
        end else begin
          res_status = gsa_pkg::ST_INVALID;
        end
      end
      gsa_pkg::OP_CHECK: begin
        res_hv = gen_match;
      end
      default: begin
        res_status = gsa_pkg::ST_OK;
      end
    endcase
    // clearing pass owns the write port
    if (state_r == S_CLEAR) begin
      we      = 1'b1;
      wr_addr = clr_cnt_r;
      wr_next = PTR_W'(clr_cnt_r) + 1'b1;
      wr_gen  = '0;
    end
  end

  // Sequence: clear, accept, execute
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Advance the result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == S_EXEC && can_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      free_head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      free_head_r <= free_head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the operation on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_opcode;
      hidx_r     <= in_handle_index;
      hgen_r     <= in_handle_generation;
      addr_r     <= rd_addr;
      in_range_r <= (in_idx_ext < 32'(SLOT_COUNT));
      full_r     <= (free_head_r >= EMPTY_MARK);
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (state_r == S_EXEC && can_load) begin
      out_idx_r    <= res_idx;
      out_gen_r    <= res_gen;
      out_hv_r     <= res_hv;
      out_status_r <= res_status;
    end
  end

  // Slot memories: one read, one write per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      next_mem[wr_addr] <= wr_next;
      gen_mem[wr_addr]  <= wr_gen;
    end
    next_rd_r <= next_mem[rd_addr];
    gen_rd_r  <= gen_mem[rd_addr];
  end

  assign out_valid           = out_valid_r;
  assign out_slot_index      = out_idx_r;
  assign out_slot_generation = out_gen_r;
  assign out_handle_valid    = out_hv_r;
  assign out_status          = out_status_r;

endmodule

[rtl/gsa_checker.sv]
module gsa_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [gsa_pkg::HANDLE_IDX_W-1:0] out_slot_index,
  input logic [gsa_pkg::GEN_W-1:0]        out_slot_generation,
  input logic                             out_handle_valid,
  input logic [gsa_pkg::STATUS_W-1:0]     out_status
);

  // One operation at a time: a transfer closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted in back-to-back cycles");

  // A full pool reports no handle
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == gsa_pkg::ST_FULL |->
      !out_handle_valid && out_slot_generation == '0)
    else $error("pool-full result carries handle data");

  // A rejected release never reports a valid handle
  a_invalid_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == gsa_pkg::ST_INVALID |->
      !out_handle_valid && out_slot_generation == '0)
    else $error("invalid-handle result flagged valid");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_slot_index) &&
      $stable(out_slot_generation) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind generational_slot_allocator_core gsa_checker u_gsa_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_slot_index      (out_slot_index),
  .out_slot_generation (out_slot_generation),
  .out_handle_valid    (out_handle_valid),
  .out_status          (out_status)
);
